>>> sv/distance_cutoff_score_sum_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distance cutoff score sum unit
// Each macro expects clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_CUTOFF_SCORE_SUM_UNIT_DEFINES_SVH
`define DISTANCE_CUTOFF_SCORE_SUM_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dcss_pkg.sv
// ----------------------------------------------------------------------------
// dcss_pkg
// Shared widths, codes and control structs of the distance cutoff score unit.
// ----------------------------------------------------------------------------
package dcss_pkg;

  localparam int CUTOFF_W = 16;
  localparam int COUNT_W  = 16;
  localparam int SCORE_W  = 17;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 32;
  localparam int D2_W     = 32;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;
  // squared distances saturate here
  localparam logic [62:0] SQ_CAP = 63'h4000_0000_0000_0000;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RESIDUES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED   = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUES = 1'd1;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET   = 16'd256;
  localparam logic [COUNT_W-1:0]  RESIDUES_RESET = 16'd1;

  typedef struct packed {
    logic idle;
    logic done;
  } sq_stat_t;

  typedef struct packed {
    logic start;
    logic score_mode;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_rsp_t;

endpackage

>>> sv/dcss_sq.sv
// ----------------------------------------------------------------------------
// dcss_sq
// Three bit-serial squaring lanes followed by a three-step sum that saturates at SQ_CAP when DIST_W is 63 or more.
// ----------------------------------------------------------------------------
module dcss_sq import dcss_pkg::*; #(
  parameter int MAG_W  = 20,
  parameter int DIST_W = 42
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2:0][MAG_W-1:0]  mag,
  output sq_stat_t               stat,
  output logic [DIST_W-1:0]      dist_sum
);

  localparam int SQ_W  = 2 * MAG_W;
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM} sq_state_t;

  sq_state_t                state;
  logic [CNT_W-1:0]         cnt;
  logic                     done;
  logic [2:0][MAG_W-1:0]    hi;
  logic [2:0][MAG_W-1:0]    lo;
  logic [2:0][MAG_W-1:0]    mc;
  logic [2:0][MAG_W:0]      step_sum;
  logic [2:0][SQ_W-1:0]     prod;
  logic [2:0][DIST_W-1:0]   sq_c;
  logic [DIST_W-1:0]        sq_sel;
  logic [DIST_W:0]          acc;
  logic [DIST_W-1:0]        dist_sum_next;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    // shift-right multiplier: one multiplier bit per cycle, narrow adder
    assign step_sum[i] = {1'b0, hi[i]} + ({1'b0, mc[i]} & {(MAG_W + 1){lo[i][0]}});
    assign prod[i]     = {hi[i], lo[i]};
    if (SQ_W > 62) begin : g_cap
      assign sq_c[i] = (prod[i] >= SQ_W'(SQ_CAP)) ? DIST_W'(SQ_CAP) : DIST_W'(prod[i]);
    end else begin : g_nocap
      assign sq_c[i] = DIST_W'(prod[i]);
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    sq_sel = sq_c[0];
      2'd1:    sq_sel = sq_c[1];
      default: sq_sel = sq_c[2];
    endcase
  end

  assign acc = {1'b0, dist_sum} + {1'b0, sq_sel};

  if (DIST_W >= 63) begin : g_sum_cap
    assign dist_sum_next = (acc > (DIST_W + 1)'(SQ_CAP)) ? DIST_W'(SQ_CAP)
                                                         : acc[DIST_W-1:0];
  end else begin : g_sum_plain
    assign dist_sum_next = acc[DIST_W-1:0];
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            hi       <= '0;
            lo       <= mag;
            mc       <= mag;
            dist_sum <= '0;
            cnt      <= CNT_W'(MAG_W);
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          for (int i = 0; i < 3; i++) begin
            hi[i] <= step_sum[i][MAG_W:1];
            lo[i] <= {step_sum[i][0], lo[i][MAG_W-1:1]};
          end
          if (cnt == CNT_W'(1)) begin
            cnt   <= '0;
            state <= S_SUM;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_SUM: begin
          dist_sum <= dist_sum_next;
          if (cnt == CNT_W'(2)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/dcss_div.sv
// ----------------------------------------------------------------------------
// dcss_div
// Restoring divider, one quotient bit per cycle, shared by term and score.
// ----------------------------------------------------------------------------
module dcss_div import dcss_pkg::*; #(
  parameter int DEN_W          = 43,
  parameter int QUO_W          = 17,
  parameter int TERM_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [DEN_W-1:0]  num,
  input  logic [DEN_W-1:0]  den_in,
  output div_rsp_t          rsp,
  output logic [QUO_W-1:0]  quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  typedef enum logic {D_IDLE, D_RUN} div_state_t;

  div_state_t          state;
  logic [CNT_W-1:0]    cnt;
  logic [DEN_W:0]      rem;
  logic [DEN_W-1:0]    den;
  logic                done;
  logic                ovf;
  logic                ge;
  logic [DEN_W:0]      diff;

  assign ge   = (rem >= {1'b0, den});
  assign diff = ge ? (rem - {1'b0, den}) : rem;

  assign rsp.done = done;
  assign rsp.ovf  = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            rem   <= {1'b0, num};
            den   <= den_in;
            quo   <= '0;
            // numerator top part at or above twice the divisor: quotient too wide
            ovf   <= ({1'b0, num} >= {den_in, 1'b0});
            cnt   <= req.score_mode ? CNT_W'(SCORE_W) : CNT_W'(TERM_FRAC_BITS + 1);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= {diff[DEN_W-1:0], 1'b0};
          quo <= {quo[QUO_W-2:0], ge};
          if (cnt == CNT_W'(1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
          cnt <= cnt - CNT_W'(1);
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

>>> sv/distance_cutoff_score_sum_unit.sv
// ----------------------------------------------------------------------------
// distance_cutoff_score_sum_unit: a new pair enters once the squaring lanes are idle and the
// pending slot is free, so intake is paced by the bit-serial lanes and the hand-off to the term
// divide, which overlaps the next pair (above TERM_FRAC_BITS = COORD_WIDTH+3 the divide sets the
// pace). The score follows the last pair through the lanes, the term divide and the score divide.
// Sync reset clears control and sum, cutoff to 1.0, residue count to 1; no clearing pass.
// ----------------------------------------------------------------------------
module distance_cutoff_score_sum_unit import dcss_pkg::*; #(
  parameter int COORD_WIDTH    = 20,
  parameter int TERM_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic                          last_pair,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SCORE_W-1:0]            score,
  output logic [STATUS_W-1:0]           status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CUTOFF_W-1:0]           cfg_data
);

  localparam int MAG_W    = COORD_WIDTH;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int DIST_W   = (SQ_W + 2 > 63) ? 63 : SQ_W + 2;
  localparam int DEN_A    = (DIST_W > SUM_W) ? DIST_W : SUM_W;
  localparam int DEN_B    = (DEN_A > COUNT_W + TERM_FRAC_BITS) ? DEN_A
                                                               : COUNT_W + TERM_FRAC_BITS;
  localparam int DEN_W    = DEN_B + 1;
  localparam int TERM_W   = TERM_FRAC_BITS + 1;
  localparam int QUO_W    = (TERM_W > SCORE_W) ? TERM_W : SCORE_W;

  typedef enum logic [2:0] {C_IDLE, C_TERM, C_SCORE_GO, C_SCORE, C_OUT} ctrl_state_t;

  ctrl_state_t              state;
  logic [CUTOFF_W-1:0]      cutoff_distance;
  logic [COUNT_W-1:0]       residue_count;
  logic [D2_W-1:0]          d2;
  logic [SUM_W-1:0]         term_sum;
  logic                     sq_last;
  logic                     pend_valid;
  logic                     pend_last;
  logic [DIST_W-1:0]        pend_dist;
  logic                     cur_last;
  logic [SCORE_W-1:0]       res_score;
  logic [STATUS_W-1:0]      res_status;

  logic                     in_accept;
  logic [2:0][MAG_W-1:0]    mag;
  sq_stat_t                 sq_stat;
  logic [DIST_W-1:0]        sq_dist;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic [DEN_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [QUO_W-1:0]         div_quo;
  logic [TERM_W-1:0]        term;
  logic [SUM_W:0]           sum_wide;
  logic [SUM_W-1:0]         sum_sat;

  // the lanes start only once the pending slot is free, so it is empty at every done
  assign in_stall  = rst || !sq_stat.idle || sq_stat.done || pend_valid;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = !rst;

  // coordinate differences and magnitudes; |a-b| always fits COORD_WIDTH bits
  always_comb begin
    logic [2:0][COORD_WIDTH-1:0] ca;
    logic [2:0][COORD_WIDTH-1:0] cb;
    logic [COORD_WIDTH:0]        dif;
    logic [COORD_WIDTH:0]        absd;
    ca = {first_z, first_y, first_x};
    cb = {second_z, second_y, second_x};
    for (int i = 0; i < 3; i++) begin
      dif    = {ca[i][COORD_WIDTH-1], ca[i]} - {cb[i][COORD_WIDTH-1], cb[i]};
      absd   = dif[COORD_WIDTH] ? (~dif + (COORD_WIDTH + 1)'(1)) : dif;
      mag[i] = absd[COORD_WIDTH-1:0];
    end
  end

  dcss_sq #(
    .MAG_W  (MAG_W),
    .DIST_W (DIST_W)
  ) u_sq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .mag      (mag),
    .stat     (sq_stat),
    .dist_sum (sq_dist)
  );

  assign div_req.start      = (state == C_IDLE && pend_valid) || (state == C_SCORE_GO);
  assign div_req.score_mode = (state == C_SCORE_GO);
  assign div_num = div_req.score_mode ? DEN_W'(term_sum) : DEN_W'(d2);
  assign div_den = div_req.score_mode ? (DEN_W'(residue_count) << TERM_FRAC_BITS)
                                      : (DEN_W'(d2) + DEN_W'(pend_dist));

  dcss_div #(
    .DEN_W          (DEN_W),
    .QUO_W          (QUO_W),
    .TERM_FRAC_BITS (TERM_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .num    (div_num),
    .den_in (div_den),
    .rsp    (div_rsp),
    .quo    (div_quo)
  );

  // zero cutoff gives a zero term, even at zero distance
  assign term     = (d2 == '0) ? '0 : div_quo[TERM_W-1:0];
  assign sum_wide = {1'b0, term_sum} + (SUM_W + 1)'(term);
  assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // user must make cutoff changes only while idle (not enforced); d2 is registered
  always_ff @(posedge clk) begin
    d2 <= D2_W'({16'b0, cutoff_distance} * {16'b0, cutoff_distance});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= C_IDLE;
      cutoff_distance <= CUTOFF_RESET;
      residue_count   <= RESIDUES_RESET;
      term_sum        <= '0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUTOFF:   cutoff_distance <= cfg_data;
          REG_RESIDUES: residue_count   <= cfg_data;
          default: ;
        endcase
      end

      if (in_accept) begin
        sq_last <= last_pair;
      end

      if (sq_stat.done) begin
        pend_valid <= 1'b1;
        pend_dist  <= sq_dist;
        pend_last  <= sq_last;
      end

      // C_OUT reloads the register itself on a transfer
      if (out_valid && !out_stall && state != C_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        C_IDLE: begin
          if (pend_valid) begin
            pend_valid <= 1'b0;
            cur_last   <= pend_last;
            state      <= C_TERM;
          end
        end
        C_TERM: begin
          if (div_rsp.done) begin
            if (!cur_last) begin
              term_sum <= sum_sat;
              state    <= C_IDLE;
            end else if (residue_count == '0) begin
              res_score  <= '0;
              res_status <= ST_NO_RESIDUES;
              term_sum   <= '0;
              state      <= C_OUT;
            end else begin
              term_sum <= sum_sat;
              state    <= C_SCORE_GO;
            end
          end
        end
        C_SCORE_GO: begin
          // divider latches the sum on this edge
          term_sum <= '0;
          state    <= C_SCORE;
        end
        C_SCORE: begin
          if (div_rsp.done) begin
            if (div_rsp.ovf || div_quo[SCORE_W-1:0] > SCORE_ONE) begin
              res_score  <= SCORE_ONE;
              res_status <= ST_SATURATED;
            end else begin
              res_score  <= div_quo[SCORE_W-1:0];
              res_status <= ST_OK;
            end
            state <= C_OUT;
          end
        end
        C_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            score     <= res_score;
            status    <= res_status;
            state     <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

>>> sv/dcss_chk.sv
// ----------------------------------------------------------------------------
// dcss_chk
// Port-level checks on the result channel of the score unit.
// ----------------------------------------------------------------------------
`include "distance_cutoff_score_sum_unit_defines.svh"

module dcss_chk import dcss_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SCORE_W-1:0]  score,
  input logic [STATUS_W-1:0] status
);

  `DCSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(score) && $stable(status), "stalled result changed")
  `DCSS_ASSERT_NOW(a_sat_one, out_valid && status == ST_SATURATED, score == SCORE_ONE, "saturated score not 1.0")
  `DCSS_ASSERT_NOW(a_noq_zero, out_valid && status == ST_NO_RESIDUES, score == '0, "zero residue count with nonzero score")
  `DCSS_ASSERT_NOW(a_ok_range, out_valid && status == ST_OK, score <= SCORE_ONE, "score above 1.0 without saturation")

endmodule

bind distance_cutoff_score_sum_unit dcss_chk u_dcss_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .score     (score),
  .status    (status)
);

>>> tb/distance_cutoff_score_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_cutoff_score_sum_checker
// Watches the pair, score and register channels of the score sum unit. Keeps
// its own copy of the cutoff, residue count and running term sum, predicts the
// score of every subset and compares it with each score transfer in order.
// ----------------------------------------------------------------------------
module distance_cutoff_score_sum_checker import dcss_pkg::*; #(
  parameter int COORD_WIDTH    = 20,
  parameter int TERM_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic                          last_pair,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [SCORE_W-1:0]            score,
  input  logic [STATUS_W-1:0]           status,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CUTOFF_W-1:0]           cfg_data,
  output int                            mismatches,
  output int                            pending
);

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [STATUS_W-1:0] status;
  } subset_score_t;

  localparam u64_t SQ_LIMIT = u64_t'(1) << 62;
  localparam u64_t SUM_MAX  = 64'hFFFF_FFFF;

  subset_score_t       score_queue[$];
  logic [CUTOFF_W-1:0] cutoff_q;
  logic [COUNT_W-1:0]  residues_q;
  u64_t                term_sum_q;
  logic [COUNT_W-1:0]  pair_count_q;

  function automatic u64_t axis_square(logic signed [COORD_WIDTH-1:0] a,
                                       logic signed [COORD_WIDTH-1:0] b);
    logic signed [63:0] diff;
    u64_t               mag;
    diff = 64'(a) - 64'(b);
    mag  = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
    if (mag >= (u64_t'(1) << 31)) return SQ_LIMIT;
    return mag * mag;
  endfunction

  // d^2 * 2^F / (d^2 + dist^2), truncated
  function automatic u64_t cutoff_term(logic [CUTOFF_W-1:0] cutoff,
                                       logic signed [COORD_WIDTH-1:0] ax,
                                       logic signed [COORD_WIDTH-1:0] ay,
                                       logic signed [COORD_WIDTH-1:0] az,
                                       logic signed [COORD_WIDTH-1:0] bx,
                                       logic signed [COORD_WIDTH-1:0] by,
                                       logic signed [COORD_WIDTH-1:0] bz);
    u64_t dist2;
    u64_t d2;
    dist2 = axis_square(ax, bx) + axis_square(ay, by);
    if (dist2 > SQ_LIMIT) dist2 = SQ_LIMIT;
    dist2 = dist2 + axis_square(az, bz);
    if (dist2 > SQ_LIMIT) dist2 = SQ_LIMIT;
    d2 = u64_t'(cutoff) * u64_t'(cutoff);
    if (d2 == 0) return '0;
    return (d2 << TERM_FRAC_BITS) / (d2 + dist2);
  endfunction

  function automatic subset_score_t subset_score(u64_t sum, logic [COUNT_W-1:0] q);
    subset_score_t r;
    u64_t          quo;
    if (q == 0) begin
      r.score  = '0;
      r.status = ST_NO_RESIDUES;
    end else begin
      quo = (sum << 16) / (u64_t'(q) << TERM_FRAC_BITS);
      if (quo > u64_t'(SCORE_ONE)) begin
        r.score  = SCORE_ONE;
        r.status = ST_SATURATED;
      end else begin
        r.score  = quo[SCORE_W-1:0];
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    subset_score_t exp_score;
    if (rst) begin
      mismatches   = 0;
      cutoff_q     = CUTOFF_RESET;
      residues_q   = RESIDUES_RESET;
      term_sum_q   = '0;
      pair_count_q = '0;
      score_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (score_queue.size() == 0) begin
          $display("%0t: score transfer with nothing expected, score %0d status %0d",
                   $time, score, status);
          mismatches++;
        end else begin
          exp_score = score_queue.pop_front();
          if (score !== exp_score.score) begin
            $display("%0t: score mismatch, expected %0d, actual %0d",
                     $time, exp_score.score, score);
            mismatches++;
          end
          if (status !== exp_score.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_score.status, status);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUTOFF:   cutoff_q   = cfg_data;
          REG_RESIDUES: residues_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        term_sum_q = term_sum_q + cutoff_term(cutoff_q, first_x, first_y, first_z,
                                              second_x, second_y, second_z);
        if (term_sum_q > SUM_MAX) term_sum_q = SUM_MAX;
        if (pair_count_q != '1) pair_count_q++;
        if (last_pair) begin
          score_queue.push_back(subset_score(term_sum_q, residues_q));
          term_sum_q   = '0;
          pair_count_q = '0;
        end
      end
    end
    pending = score_queue.size();
  end

endmodule

>>> tb/distance_cutoff_score_sum_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_cutoff_score_sum_unit_test
// Drives coordinate pair subsets into the score sum unit under several cutoff
// and residue count settings, with random gaps on both sides and one long
// score hold-off. A checker beside the block predicts and compares scores.
// ----------------------------------------------------------------------------
module distance_cutoff_score_sum_unit_test;
  import dcss_pkg::*;

  localparam int COORD_WIDTH    = 20;
  localparam int TERM_FRAC_BITS = 16;
  localparam int DRAIN_CYCLES   = COORD_WIDTH + TERM_FRAC_BITS + 27 + 40;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_PAIRS    = 115;
  localparam int COORD_MAX      = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int BASE_SPAN      = COORD_MAX - 140000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
  } atom_pair_t;

  localparam int PAIR_W = $bits(atom_pair_t);

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [COORD_WIDTH-1:0] first_x = '0;
  logic signed [COORD_WIDTH-1:0] first_y = '0;
  logic signed [COORD_WIDTH-1:0] first_z = '0;
  logic signed [COORD_WIDTH-1:0] second_x = '0;
  logic signed [COORD_WIDTH-1:0] second_y = '0;
  logic signed [COORD_WIDTH-1:0] second_z = '0;
  logic                          last_pair = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [SCORE_W-1:0]            score;
  logic [STATUS_W-1:0]           status;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CUTOFF_W-1:0]           cfg_data = '0;

  int mismatches;
  int pending;
  bit sender_calm = 1'b0;
  bit sink_calm   = 1'b0;
  int hold_requests = 0;
  int holds_done    = 0;
  int cur_cutoff    = 256;

  distance_cutoff_score_sum_unit #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TERM_FRAC_BITS(TERM_FRAC_BITS)
  ) u_top (.*);

  distance_cutoff_score_sum_checker #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TERM_FRAC_BITS(TERM_FRAC_BITS)
  ) u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // score side: random stall before each transfer, plus one long hold-off on request
  initial begin : score_sink
    int gap;
    @(posedge clk iff !rst);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = sink_calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  function automatic int random_base();
    return int'($urandom_range(0, 2 * BASE_SPAN)) - BASE_SPAN;
  endfunction

  function automatic int random_delta(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] corner_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_WIDTH'(COORD_MAX);
      1:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic atom_pair_t make_pair(int cutoff);
    atom_pair_t p;
    int         lim;
    int         mode;
    int         a;
    lim  = 2 * cutoff + 1;
    mode = $urandom_range(0, 99);
    if (mode < 50) begin
      a = random_base(); p.ax = COORD_WIDTH'(a); p.bx = COORD_WIDTH'(a + random_delta(lim));
      a = random_base(); p.ay = COORD_WIDTH'(a); p.by = COORD_WIDTH'(a + random_delta(lim));
      a = random_base(); p.az = COORD_WIDTH'(a); p.bz = COORD_WIDTH'(a + random_delta(lim));
    end else if (mode < 65) begin
      a = random_base(); p.ax = COORD_WIDTH'(a); p.bx = COORD_WIDTH'(a);
      a = random_base(); p.ay = COORD_WIDTH'(a); p.by = COORD_WIDTH'(a);
      a = random_base(); p.az = COORD_WIDTH'(a); p.bz = COORD_WIDTH'(a);
    end else if (mode < 90) begin
      p = PAIR_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else begin
      p.ax = corner_coord(); p.ay = corner_coord(); p.az = corner_coord();
      p.bx = corner_coord(); p.by = corner_coord(); p.bz = corner_coord();
    end
    return p;
  endfunction

  task automatic offer_pair(atom_pair_t p, logic last);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    first_x   <= p.ax;
    first_y   <= p.ay;
    first_z   <= p.az;
    second_x  <= p.bx;
    second_y  <= p.by;
    second_z  <= p.bz;
    last_pair <= last;
    in_valid  <= 1'b1;
    @(posedge clk iff !in_stall);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CUTOFF_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CUTOFF) cur_cutoff = int'(data);
  endtask

  // stop offering, wait for every score, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_subsets(int n_pairs, int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < n_pairs) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
        offer_pair(make_pair(cur_cutoff), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    atom_pair_t same;
    atom_pair_t spread;
    atom_pair_t spread_rev;
    atom_pair_t at_cutoff;
    int         cutoff;
    int         residues;
    int         max_len;

    same       = '0;
    spread     = {COORD_MAX[COORD_WIDTH-1:0], COORD_MAX[COORD_WIDTH-1:0],
                  COORD_MAX[COORD_WIDTH-1:0], {3{1'b1, {(COORD_WIDTH-1){1'b0}}}}};
    spread_rev = {spread.bx, spread.by, spread.bz, spread.ax, spread.ay, spread.az};
    at_cutoff  = '0;
    at_cutoff.ax = COORD_WIDTH'(256);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: cutoff 1.0 A, q = 1
    offer_pair(same, 1'b1);
    offer_pair(spread, 1'b1);
    offer_pair(spread_rev, 1'b1);
    offer_pair(at_cutoff, 1'b1);
    offer_pair(same, 1'b0);
    offer_pair(same, 1'b1);
    settle();

    // zero residue count reports an error, sum still cleared
    write_reg(REG_RESIDUES, '0);
    offer_pair(same, 1'b1);
    offer_pair(at_cutoff, 1'b0);
    offer_pair(same, 1'b1);
    settle();

    // zero cutoff: every term is zero, even at distance zero
    write_reg(REG_CUTOFF, '0);
    write_reg(REG_RESIDUES, 16'd1);
    offer_pair(same, 1'b1);
    offer_pair(spread, 1'b1);
    settle();

    write_reg(REG_CUTOFF, 16'hFFFF);
    write_reg(REG_RESIDUES, 16'd2);
    offer_pair(spread, 1'b0);
    offer_pair(same, 1'b1);
    offer_pair(at_cutoff, 1'b1);
    settle();

    write_reg(REG_CUTOFF, 16'd1);
    write_reg(REG_RESIDUES, 16'hFFFF);
    offer_pair(same, 1'b1);
    offer_pair(spread_rev, 1'b1);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       cutoff = 1;
        1:       cutoff = 65535;
        2:       cutoff = 0;
        default: cutoff = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 65535)
                                                       : $urandom_range(64, 2048);
      endcase
      case (ph)
        3:       residues = 0;
        4:       residues = 65535;
        6:       residues = 1;
        default: residues = $urandom_range(1, 12);
      endcase
      max_len     = (ph == 5) ? 1 : 12;
      sender_calm = (ph % 4 == 3) || (ph % 6 == 0);
      sink_calm   = (ph % 4 == 1) || (ph % 6 == 0);
      write_reg(REG_CUTOFF, cutoff[CUTOFF_W-1:0]);
      write_reg(REG_RESIDUES, residues[COUNT_W-1:0]);
      // single-pair subsets behind a long score hold-off back up the pipeline
      if (ph == 5) hold_requests++;
      run_subsets(PHASE_PAIRS, max_len);
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
